### design/assert_macros.svh
// Assertion macros shared by the token bucket shaper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TBS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TBS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TBS_ASSERT(name, prop, msg)
`define TBS_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### design/tbs_pkg.sv
// Types and event codes shared by the token bucket shaper modules.
`timescale 1ns / 1ps

package tbs_pkg;

    localparam int ID_W    = 16;
    localparam int TOKEN_W = 10;
    localparam int EVENT_W = 3;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TOKEN  = 1'b1;

    localparam logic [EVENT_W-1:0] EV_TOO_BIG  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_FULL     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_QUEUED   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_RELEASED = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TOK_ADD  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TOK_DROP = 3'd5;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    packet_id;
        logic [TOKEN_W-1:0] tokens_needed;
    } req_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [ID_W-1:0]    event_packet_id;
        logic [TOKEN_W-1:0] bucket_level;
        logic               last;
    } evt_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    packet_id;
        logic [TOKEN_W-1:0] need;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

### design/tbs_cell.sv
// One queue cell: holds one waiting packet and takes its neighbor's entry on a pop.
`timescale 1ns / 1ps

module tbs_cell
    import tbs_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     neighbor_entry,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbor_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### design/tbs_queue.sv
// Wait queue built as a chain of cells with the head in cell zero and a fill counter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbs_queue
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_ctrl_t   ctrl,
    input  entry_t        push_entry,
    output entry_t        head_entry,
    output queue_status_t status
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    entry_t            cell_entry [QUEUE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            cell_ctrl_t cctrl;
            entry_t     neighbor;

            assign cctrl.load_new = ctrl.push && (fill_reg == FILL_W'(i));
            assign cctrl.shift    = ctrl.pop;

            if (i == QUEUE_DEPTH - 1)
            begin : g_end
                assign neighbor = cell_entry[i];
            end
            else
            begin : g_mid
                assign neighbor = cell_entry[i + 1];
            end

            tbs_cell u_cell (
                .clk            (clk),
                .ctrl           (cctrl),
                .new_entry      (push_entry),
                .neighbor_entry (neighbor),
                .entry          (cell_entry[i])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.push)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (ctrl.pop)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign head_entry   = cell_entry[0];
    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == FILL_W'(QUEUE_DEPTH));

    `TBS_ASSERT(a_fill_bound, fill_reg <= FILL_W'(QUEUE_DEPTH), "queue fill beyond depth")
    `TBS_ASSERT(a_push_not_full, ctrl.push |-> !status.full, "push into a full queue")
    `TBS_ASSERT(a_pop_not_empty, ctrl.pop |-> !status.empty, "pop from an empty queue")

endmodule

### design/token_bucket_packet_shaper.sv
// Top level of the token bucket packet shaper.
// An item's first result is offered in the cycle after the item is accepted.
// An item holds the block until its one or two results are taken; the two-entry output
// register drains one result per cycle when evt_stall is low and gates acceptance.
// Reset clears the token count, the queue fill count and the output valid flags, and sets the
// bucket depth to 10; queue cells are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module token_bucket_packet_shaper
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_item_t          req_data,
    output logic               evt_valid,
    input  logic               evt_stall,
    output evt_item_t          evt_data,
    input  logic               cfg_wr_en,
    input  logic [TOKEN_W-1:0] cfg_wr_data
);

    logic [TOKEN_W-1:0] depth_reg;
    logic [TOKEN_W-1:0] tokens_reg;
    logic [TOKEN_W-1:0] tokens_next;
    logic               valid_reg;
    logic               two_reg;
    evt_item_t          res0_reg;
    evt_item_t          res1_reg;

    evt_item_t          res0;
    evt_item_t          res1;
    logic               two;
    logic               accept;
    logic               taken;
    logic [TOKEN_W-1:0] tok_inc;
    logic [EVENT_W-1:0] tok_ev;
    queue_ctrl_t        qctrl;
    queue_status_t      qstat;
    entry_t             head;
    entry_t             push_entry;

    tbs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (qctrl),
        .push_entry (push_entry),
        .head_entry (head),
        .status     (qstat)
    );

    assign taken     = valid_reg && !evt_stall;
    assign req_stall = valid_reg && !(taken && !two_reg);
    assign accept    = req_valid && !req_stall;

    assign push_entry.packet_id = req_data.packet_id;
    assign push_entry.need      = req_data.tokens_needed;

    always_comb
    begin
        tok_inc     = tokens_reg;
        tok_ev      = EV_TOK_DROP;
        res0        = '0;
        res1        = '0;
        two         = 1'b0;
        qctrl       = '0;
        tokens_next = tokens_reg;
        if (tokens_reg < depth_reg)
        begin
            tok_inc = tokens_reg + TOKEN_W'(1);
            tok_ev  = EV_TOK_ADD;
        end
        if (req_data.kind == KIND_PACKET)
        begin
            res0.event_packet_id = req_data.packet_id;
            res0.bucket_level    = tokens_reg;
            res0.last            = 1'b1;
            if (req_data.tokens_needed > depth_reg)
            begin
                res0.event_res = EV_TOO_BIG;
            end
            else if (qstat.full)
            begin
                res0.event_res = EV_FULL;
            end
            else if (qstat.empty && (tokens_reg >= req_data.tokens_needed))
            begin
                res0.event_res       = EV_QUEUED;
                res0.last            = 1'b0;
                tokens_next          = tokens_reg - req_data.tokens_needed;
                res1.event_res       = EV_RELEASED;
                res1.event_packet_id = req_data.packet_id;
                res1.bucket_level    = tokens_next;
                res1.last            = 1'b1;
                two                  = 1'b1;
            end
            else
            begin
                res0.event_res = EV_QUEUED;
                qctrl.push     = accept;
            end
        end
        else
        begin
            res0.event_res    = tok_ev;
            res0.bucket_level = tok_inc;
            res0.last         = 1'b1;
            tokens_next       = tok_inc;
            if (!qstat.empty && (tok_inc >= head.need))
            begin
                res0.last            = 1'b0;
                tokens_next          = tok_inc - head.need;
                res1.event_res       = EV_RELEASED;
                res1.event_packet_id = head.packet_id;
                res1.bucket_level    = tokens_next;
                res1.last            = 1'b1;
                two                  = 1'b1;
                qctrl.pop            = accept;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= TOKEN_W'(10);
            tokens_reg <= '0;
            valid_reg  <= 1'b0;
            two_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                depth_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                tokens_reg <= tokens_next;
                valid_reg  <= 1'b1;
                two_reg    <= two;
            end
            else if (taken)
            begin
                if (two_reg)
                begin
                    two_reg <= 1'b0;
                end
                else
                begin
                    valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res0_reg <= res0;
            res1_reg <= res1;
        end
        else if (taken && two_reg)
        begin
            res0_reg <= res1_reg;
        end
    end

    assign evt_valid = valid_reg;
    assign evt_data  = res0_reg;

    `TBS_ASSERT(a_accept_offers, accept |=> evt_valid, "accepted item gives no result")
    `TBS_ASSERT(a_second_follows, (taken && two_reg) |=> (evt_valid && evt_data.last),
        "second result of an item lost")
    `TBS_ASSERT(a_last_matches, evt_valid |-> (evt_data.last == !two_reg),
        "last flag disagrees with pending results")

endmodule

### tb/tb_token_bucket_packet_shaper.sv
// Self-checking testbench for the token bucket packet shaper with a built-in event predictor.
`timescale 1ns / 1ps

module tb_token_bucket_packet_shaper;
    import tbs_pkg::*;

    localparam int QDEPTH      = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 6;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               req_valid   = 1'b0;
    logic               req_stall;
    req_item_t          req_data    = '0;
    logic               evt_valid;
    logic               evt_stall   = 1'b0;
    evt_item_t          evt_data;
    logic               cfg_wr_en   = 1'b0;
    logic [TOKEN_W-1:0] cfg_wr_data = '0;

    logic [TOKEN_W-1:0] depth_reg = TOKEN_W'(10);
    logic [TOKEN_W-1:0] held      = '0;
    entry_t             waiting[$];
    evt_item_t          pending_events[$];

    int  errors       = 0;
    int  items_sent   = 0;
    int  events_seen  = 0;
    int  full_drops   = 0;
    int  big_drops    = 0;
    int  releases     = 0;
    int  cycles       = 0;
    int  stall_hold   = 0;
    bit  no_gaps      = 1'b0;

    always #4 clk = ~clk;

    token_bucket_packet_shaper #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_data   (evt_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    function automatic void push_event(logic [EVENT_W-1:0] code, logic [ID_W-1:0] id,
                                       logic [TOKEN_W-1:0] lvl, logic fin);
        evt_item_t e;
        e.event_res       = code;
        e.event_packet_id = id;
        e.bucket_level    = lvl;
        e.last            = fin;
        pending_events.push_back(e);
    endfunction

    function automatic void predict_arrival(req_item_t it);
        entry_t             head;
        logic [EVENT_W-1:0] tok_code;
        if (it.kind == KIND_PACKET)
        begin
            if (it.tokens_needed > depth_reg)
            begin
                big_drops++;
                push_event(EV_TOO_BIG, it.packet_id, held, 1'b1);
            end
            else if (waiting.size() >= QDEPTH)
            begin
                full_drops++;
                push_event(EV_FULL, it.packet_id, held, 1'b1);
            end
            else if (waiting.size() == 0 && held >= it.tokens_needed)
            begin
                releases++;
                push_event(EV_QUEUED, it.packet_id, held, 1'b0);
                held = held - it.tokens_needed;
                push_event(EV_RELEASED, it.packet_id, held, 1'b1);
            end
            else
            begin
                head.packet_id = it.packet_id;
                head.need      = it.tokens_needed;
                waiting.push_back(head);
                push_event(EV_QUEUED, it.packet_id, held, 1'b1);
            end
        end
        else
        begin
            if (held < depth_reg)
            begin
                held     = held + TOKEN_W'(1);
                tok_code = EV_TOK_ADD;
            end
            else
            begin
                tok_code = EV_TOK_DROP;
            end
            if (waiting.size() > 0 && held >= waiting[0].need)
            begin
                releases++;
                head = waiting.pop_front();
                push_event(tok_code, '0, held, 1'b0);
                held = held - head.need;
                push_event(EV_RELEASED, head.packet_id, held, 1'b1);
            end
            else
            begin
                push_event(tok_code, '0, held, 1'b1);
            end
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        evt_item_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            events_seen++;
            if (pending_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, evt_data);
            end
            else
            begin
                want = pending_events.pop_front();
                check_field("event_res", int'(want.event_res), int'(evt_data.event_res));
                check_field("event_packet_id", int'(want.event_packet_id),
                            int'(evt_data.event_packet_id));
                check_field("bucket_level", int'(want.bucket_level),
                            int'(evt_data.bucket_level));
                check_field("last", int'(want.last), int'(evt_data.last));
            end
        end
    end

    always @(posedge clk)
    begin
        int r;
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            r = int'($urandom_range(0, 99));
            if ((cycles / 300) % 4 == 0 || r < 60)
            begin
                evt_stall  <= 1'b0;
                stall_hold <= int'($urandom_range(0, 4));
            end
            else if (r < 92)
            begin
                evt_stall  <= 1'b1;
                stall_hold <= int'($urandom_range(0, 2));
            end
            else
            begin
                evt_stall  <= 1'b1;
                stall_hold <= int'($urandom_range(5, 30));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (no_gaps || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(5, 40));
    endfunction

    task automatic send_item(input req_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        do @(posedge clk); while (req_stall);
        predict_arrival(it);
        items_sent++;
    endtask

    function automatic req_item_t packet_item(logic [ID_W-1:0] id, logic [TOKEN_W-1:0] need);
        req_item_t it;
        it.kind          = KIND_PACKET;
        it.packet_id     = id;
        it.tokens_needed = need;
        return it;
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        return ID_W'($urandom_range(0, 65535));
    endfunction

    function automatic req_item_t token_item();
        req_item_t it;
        it.kind          = KIND_TOKEN;
        it.packet_id     = random_id();
        it.tokens_needed = TOKEN_W'($urandom_range(0, 1023));
        return it;
    endfunction

    function automatic logic [TOKEN_W-1:0] pick_need();
        int r;
        int top;
        r = int'($urandom_range(0, 31));
        if (r == 0)
        begin
            return TOKEN_W'($urandom_range(0, 1023));
        end
        if (r <= 2)
        begin
            return (depth_reg == TOKEN_W'(1023)) ? TOKEN_W'(1023) : depth_reg + TOKEN_W'(1);
        end
        if (r == 3)
        begin
            return depth_reg;
        end
        top = (int'(depth_reg) < 3) ? int'(depth_reg) : 3;
        return TOKEN_W'($urandom_range(0, top));
    endfunction

    function automatic logic [TOKEN_W-1:0] blocking_need();
        int top;
        if (held < depth_reg)
        begin
            top = (int'(held) + 4 < int'(depth_reg)) ? int'(held) + 4 : int'(depth_reg);
            return TOKEN_W'($urandom_range(int'(held) + 1, top));
        end
        return pick_need();
    endfunction

    task automatic pause_until_idle();
        req_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic drain_queue();
        int n;
        n = 0;
        while (waiting.size() > 0 && n < 300)
        begin
            send_item(token_item());
            n++;
        end
    endtask

    task automatic write_depth(input logic [TOKEN_W-1:0] value);
        drain_queue();
        pause_until_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        depth_reg = value;
    endtask

    task automatic packet_burst(input int len);
        send_item(packet_item(random_id(), blocking_need()));
        for (int i = 1; i < len; i++)
        begin
            send_item(packet_item(random_id(), pick_need()));
        end
    endtask

    task automatic run_random(input int count);
        int target;
        int sel;
        int len;
        target = items_sent + count;
        while (items_sent < target)
        begin
            sel     = int'($urandom_range(0, 9));
            no_gaps = ($urandom_range(0, 4) == 0);
            if (sel <= 3)
            begin
                len = ($urandom_range(0, 5) == 0) ? int'($urandom_range(60, 80))
                                                  : int'($urandom_range(1, 12));
                packet_burst(len);
            end
            else if (sel <= 6)
            begin
                repeat ($urandom_range(1, 20)) send_item(token_item());
            end
            else
            begin
                repeat ($urandom_range(1, 30))
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send_item(token_item());
                    end
                    else
                    begin
                        send_item(packet_item(random_id(), pick_need()));
                    end
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_basic_events();
        send_item(token_item());
        send_item(packet_item(16'h0000, 10'd0));
        send_item(packet_item(16'hFFFF, 10'd1023));
        send_item(packet_item(16'h1234, 10'd10));
        send_item(packet_item(16'h0002, 10'd1));
        repeat (10) send_item(token_item());
        repeat (11) send_item(token_item());
    endtask

    task automatic test_queue_full();
        write_depth(10'd1023);
        packet_burst(70);
        drain_queue();
        run_random(150);
    endtask

    task automatic test_depth_zero();
        write_depth(10'd0);
        run_random(150);
    endtask

    task automatic test_depth_lowered();
        int n;
        write_depth(10'd64);
        n = 0;
        while (held < TOKEN_W'(40) && n < 200)
        begin
            send_item(token_item());
            n++;
        end
        write_depth(10'd5);
        run_random(150);
    endtask

    task automatic test_depth_one();
        write_depth(10'd1);
        run_random(150);
    endtask

    task automatic test_mixed_depths();
        repeat (3)
        begin
            write_depth(TOKEN_W'($urandom_range(2, 40)));
            run_random(140);
        end
        write_depth(TOKEN_W'($urandom_range(1, 1023)));
        run_random(140);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_events();
        test_queue_full();
        test_depth_zero();
        test_depth_lowered();
        test_depth_one();
        test_mixed_depths();
        pause_until_idle();
        $display("Sent %0d items and checked %0d events across depths 0 to 1023.",
                 items_sent, events_seen);
        $display("Saw %0d releases, %0d oversize drops and %0d full-queue drops.",
                 releases, big_drops, full_drops);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
